[sv/gcd_pkg.sv]
package gcd_pkg;

  localparam int CordicSteps = 30;
  localparam int RadiusWidth = 13;
  localparam logic [RadiusWidth-1:0] RadiusReset = 13'd6371;
  localparam int DistWidth = 23;
  localparam logic [DistWidth-1:0] DistMax = 23'd6587600;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic [30:0] PiQ29 = 31'd1686629713;
  localparam logic signed [33:0] OneQ30 = 34'sd1073741824;
  // cycles from an accepted start to its done pulse
  localparam int Latency = 99;

  function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0: r = 34'sd536870912;
      5'd1: r = 34'sd316933406;
      5'd2: r = 34'sd167458907;
      5'd3: r = 34'sd85004756;
      5'd4: r = 34'sd42667331;
      5'd5: r = 34'sd21354465;
      5'd6: r = 34'sd10679838;
      5'd7: r = 34'sd5340245;
      5'd8: r = 34'sd2670163;
      5'd9: r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      5'd24: r = 34'sd41;
      5'd25: r = 34'sd20;
      5'd26: r = 34'sd10;
      5'd27: r = 34'sd5;
      5'd28: r = 34'sd3;
      5'd29: r = 34'sd1;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

endpackage

[sv/gcd_deg2bam.sv]
// degrees q16 to 32-bit binary angle, round half away from zero
// mag*65536/360 = mag*8192/45; reciprocal multiply with one correction
module gcd_deg2bam (
  input  logic        clk,
  input  logic signed [24:0] deg,
  output logic [31:0] bam
);
  import gcd_pkg::*;
  // 2^38 / 45 rounded down, so the quotient estimate is at most one low
  localparam logic [32:0] Recip = 33'd6108397932;
  logic        neg;
  logic [24:0] mag;
  logic [38:0] num;
  logic [71:0] prod;
  logic [32:0] q;
  logic [38:0] rem;
  logic [32:0] r;
  logic        neg_d;
  logic [38:0] num_d;
  logic [32:0] q_d;

  always_comb begin
    neg = deg[24];
    mag = neg ? 25'(-deg) : 25'(deg);
    num = {1'b0, mag, 13'd0} + 39'd22;  // (mag*65536+180)/360 == (mag*8192+22.5)/45
  end

  always_ff @(posedge clk) begin
    neg_d <= neg;
    num_d <= num;
    prod  <= 72'(num) * 72'(Recip);
  end

  always_comb begin
    q   = prod[70:38];
    rem = num_d - 39'(q) * 39'd45;
    r   = (rem >= 39'd45) ? q + 33'd1 : q;
  end

  always_ff @(posedge clk) bam <= neg_d ? 32'(-r) : r[31:0];
endmodule

[sv/gcd_sincos.sv]
// pipelined rotation-mode cordic, one step per stage, quadrant folded first
module gcd_sincos (
  input  logic               clk,
  input  logic [31:0]        ang,
  output logic signed [33:0] sin_q30,
  output logic signed [33:0] cos_q30
);
  import gcd_pkg::*;
  logic signed [33:0] x [0:CordicSteps];
  logic signed [33:0] y [0:CordicSteps];
  logic signed [33:0] z [0:CordicSteps];
  logic               fl [0:CordicSteps];
  logic [31:0]        a;
  logic               flip;

  always_comb begin
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    a = flip ? ang + 32'h8000_0000 : ang;
    x[0] = CordicGain;
    y[0] = '0;
    z[0] = 34'(signed'(a));
    fl[0] = flip;
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    always_ff @(posedge clk) begin
      fl[i+1] <= fl[i];
      if (!z[i][33]) begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - atan_entry(5'(i));
      end else begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + atan_entry(5'(i));
      end
    end
  end

  assign sin_q30 = fl[CordicSteps] ? -y[CordicSteps] : y[CordicSteps];
  assign cos_q30 = fl[CordicSteps] ? -x[CordicSteps] : x[CordicSteps];
endmodule

[sv/gcd_isqrt.sv]
// pipelined floor square root of a 60-bit value, one result bit per stage
module gcd_isqrt (
  input  logic        clk,
  input  logic [59:0] v,
  output logic [29:0] root
);
  localparam int Bits = 30;
  logic [61:0] rem [0:Bits];
  logic [29:0] r   [0:Bits];
  logic [59:0] src [0:Bits];

  assign rem[0] = '0;
  assign r[0]   = '0;
  assign src[0] = v;

  for (genvar i = 0; i < Bits; i++) begin : g_bit
    logic [61:0] cur;
    logic [61:0] trial;
    always_comb begin
      cur   = {rem[i][59:0], src[i][59:58]};
      trial = {r[i], 2'b01};
    end
    always_ff @(posedge clk) begin
      src[i+1] <= {src[i][57:0], 2'b00};
      if (cur >= trial) begin
        rem[i+1] <= cur - trial;
        r[i+1]   <= {r[i][28:0], 1'b1};
      end else begin
        rem[i+1] <= cur;
        r[i+1]   <= {r[i][28:0], 1'b0};
      end
    end
  end

  assign root = r[Bits];
endmodule

[sv/gcd_atan2.sv]
// pipelined vectoring-mode cordic for nonnegative y, x up to 2^30; clamped to [0, 2^30]
module gcd_atan2 (
  input  logic        clk,
  input  logic [30:0] y_in,
  input  logic [30:0] x_in,
  output logic [30:0] ang
);
  import gcd_pkg::*;
  logic signed [33:0] x [0:CordicSteps];
  logic signed [33:0] y [0:CordicSteps];
  logic signed [33:0] z [0:CordicSteps];

  assign x[0] = 34'(x_in);
  assign y[0] = 34'(y_in);
  assign z[0] = '0;

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (!y[i][33]) begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + atan_entry(5'(i));
      end else begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - atan_entry(5'(i));
      end
    end
  end

  always_comb begin
    if (z[CordicSteps][33]) ang = '0;
    else if (z[CordicSteps] > OneQ30) ang = 31'(OneQ30);
    else ang = z[CordicSteps][30:0];
  end
endmodule

[sv/great_circle_distance_unit.sv]
// haversine great circle distance, fully pipelined: one point pair may be
// started in every cycle (busy is always low) and its distance appears on
// distance_km with done high. the pipeline holds the angle conversion
// registers, 1 half-difference register, the 30-stage sine/cosine
// cordic, 3 product and sum registers, the 30-stage square root, the
// 30-stage atan2 cordic and 3 scaling registers. the receiver cannot stall;
// every transfer is a single-cycle done pulse. the radius register should
// only be written while no item is in flight.
module great_circle_distance_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [23:0]               lat_a,
  input  logic signed [24:0]               lon_a,
  input  logic signed [23:0]               lat_b,
  input  logic signed [24:0]               lon_b,
  input  logic                             cfg_we,
  input  logic [gcd_pkg::RadiusWidth-1:0]  cfg_data,
  output logic                             done,
  output logic [gcd_pkg::DistWidth-1:0]    distance_km
);
  import gcd_pkg::*;

  logic [RadiusWidth-1:0] radius;
  logic [Latency-1:0]     vld;

  // radius register
  always_ff @(posedge clk) begin
    if (rst) radius <= RadiusReset;
    else if (cfg_we) radius <= cfg_data;
  end

  // valid bits ride alongside the data pipeline
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[Latency-2:0], start};
  end
  assign busy = 1'b0;
  assign done = vld[Latency-1];

  // stage group 1: degrees to binary angle
  logic [31:0] la, oa, lb, ob;
  gcd_deg2bam u_la (.clk, .deg(25'(lat_a)), .bam(la));
  gcd_deg2bam u_oa (.clk, .deg(lon_a), .bam(oa));
  gcd_deg2bam u_lb (.clk, .deg(25'(lat_b)), .bam(lb));
  gcd_deg2bam u_ob (.clk, .deg(lon_b), .bam(ob));

  // half differences
  logic [31:0] hlat, hlon;
  always_ff @(posedge clk) begin
    hlat <= (lb - la) >> 1;
    hlon <= (ob - oa) >> 1;
  end
  logic [31:0] la_d, lb_d;
  always_ff @(posedge clk) begin
    la_d <= la;
    lb_d <= lb;
  end

  // stage group 2: four parallel sine/cosine chains
  logic signed [33:0] sa_u, ca, sb_u, cb, s1, c1_u, s2, c2_u;
  gcd_sincos u_sca (.clk, .ang(la_d), .sin_q30(sa_u), .cos_q30(ca));
  gcd_sincos u_scb (.clk, .ang(lb_d), .sin_q30(sb_u), .cos_q30(cb));
  gcd_sincos u_scl (.clk, .ang(hlat), .sin_q30(s1), .cos_q30(c1_u));
  gcd_sincos u_sco (.clk, .ang(hlon), .sin_q30(s2), .cos_q30(c2_u));

  // products, each registered before the next
  logic signed [67:0] p_cc, p_s1, p_s2;
  always_ff @(posedge clk) begin
    p_cc <= ca * cb;
    p_s1 <= s1 * s1;
    p_s2 <= s2 * s2;
  end
  logic signed [33:0] cc, hs1, hs2, hs1_d;
  always_comb begin
    cc  = 34'(p_cc >>> 30);
    hs1 = 34'(p_s1 >>> 30);
    hs2 = 34'(p_s2 >>> 30);
  end
  logic signed [67:0] p_t;
  always_ff @(posedge clk) begin
    p_t   <= cc * hs2;
    hs1_d <= hs1;
  end

  // haversine term, clamped to [0, 1]
  logic signed [34:0] a_sum;
  logic [30:0]        a_cl;
  always_comb begin
    a_sum = 35'(hs1_d) + 35'(34'(p_t >>> 30));
    if (a_sum[34]) a_cl = '0;
    else if (a_sum > 35'(OneQ30)) a_cl = 31'(OneQ30);
    else a_cl = a_sum[30:0];
  end
  logic [30:0] a_r;
  always_ff @(posedge clk) a_r <= a_cl;

  // stage group 3: square roots
  logic [29:0] ra, rb;
  logic [30:0] oma;
  assign oma = 31'(OneQ30) - a_r;
  gcd_isqrt u_sqa (.clk, .v({a_r[29:0], 30'd0}), .root(ra));
  gcd_isqrt u_sqb (.clk, .v({oma[29:0], 30'd0}), .root(rb));
  // a = 1 gives 2^60 which needs 61 bits; root is exactly 2^30
  logic [30:0] a_top [0:30];
  assign a_top[0] = {a_r[30], oma[30], 29'd0};
  for (genvar k = 0; k < 30; k++) begin : g_top
    always_ff @(posedge clk) a_top[k+1] <= a_top[k];
  end
  logic [30:0] ra_full, rb_full;
  assign ra_full = a_top[30][30] ? 31'h4000_0000 : 31'(ra);
  assign rb_full = a_top[30][29] ? 31'h4000_0000 : 31'(rb);

  // stage group 4: atan2; a root of exactly 2^30 goes in as is
  logic [30:0] z;
  gcd_atan2 u_atan (.clk, .y_in(ra_full), .x_in(rb_full), .ang(z));

  // stage group 5: scale by pi and radius, then round and saturate
  logic [61:0] pz;
  always_ff @(posedge clk) pz <= z * PiQ29;
  logic [33:0] u;
  assign u = 34'((pz + 62'(1 << 28)) >> 29);
  logic [46:0] ud;
  always_ff @(posedge clk) ud <= u * radius;
  logic [24:0] d;
  assign d = 25'((ud + 47'(1 << 21)) >> 22);
  always_ff @(posedge clk) distance_km <= (d > 25'(DistMax)) ? DistMax : d[22:0];
endmodule
